/* sv/tccw_pkg.sv */
// Shared types and constants of the text console character writer.
package tccw_pkg;

  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_BACKSPACE = 8'h08;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_SPACE     = 8'h20;

  localparam logic [7:0] RESET_COLUMNS = 8'd80;
  localparam logic [5:0] RESET_ROWS    = 6'd25;
  localparam logic [7:0] RESET_ATTR    = 8'h07;

  localparam logic [1:0] CFG_COLUMNS   = 2'd0;
  localparam logic [1:0] CFG_ROWS      = 2'd1;
  localparam logic [1:0] CFG_ATTRIBUTE = 2'd2;

  localparam logic OP_PUT  = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef struct packed {
    logic        operation;
    logic [7:0]  character;
    logic [11:0] cell_index;
  } in_item_t;

  typedef struct packed {
    logic [11:0] cursor_position;
    logic [7:0]  read_character;
    logic [7:0]  read_attribute;
    logic        scrolled;
  } out_item_t;

endpackage

/* sv/text_console_char_writer_unit.sv */
// Text console character writer: screen store, cursor, scroll and cell read.
//
// Input channel (in_valid_i / in_stall_o / in_data_i) takes put and read items;
// an item is taken when valid is high and stall is low. Each item gives exactly
// one result on the output channel (out_valid_o / out_stall_i / out_data_o).
// Configuration (columns, rows, attribute) is written through cfg_we_i,
// cfg_index_i and cfg_data_i; the user writes it only while the block is idle,
// which the block itself does not enforce. One item at a time: in_stall_o is
// high from acceptance until the result is loaded into the output register.
//   read                     S_RDADR, S_RDDATA, S_DONE
//   backspace, character     S_GEOM, S_DISP, S_PLACE (character), S_DONE
//   newline, tab             S_GEOM, S_DISP, S_DIV, S_PLACE, S_DONE; S_DIV
//                            is the bit-serial remainder unit over PW =
//                            clog2(cells + TAB_STOP + 1) bits (13 by default)
//   a move that scrolls      adds S_SCR_RD, S_SCR_WR per cell of total - columns
//                            copied on the single memory port pair, then S_BLANK
// A result that waits on out_stall_i holds in the output register; the next
// item is accepted meanwhile and waits in its final step for the register.
// After reset a clearing pass writes MAX_COLUMNS*MAX_ROWS cells with spaces in
// attribute 7; items are stalled during it, configuration writes are taken.
module text_console_char_writer_unit #(
  parameter int MAX_COLUMNS = 128,
  parameter int MAX_ROWS    = 32,
  parameter int TAB_STOP    = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  tccw_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output tccw_pkg::out_item_t out_data_o,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [7:0]          cfg_data_i
);

  localparam int CELL_COUNT = MAX_COLUMNS * MAX_ROWS;
  localparam int AW         = $clog2(CELL_COUNT);
  localparam int PW         = $clog2(CELL_COUNT + TAB_STOP + 1);
  localparam int CW         = $clog2(PW);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_GEOM, S_DISP, S_DIV, S_PLACE,
    S_SCR_RD, S_SCR_WR, S_BLANK, S_RDADR, S_RDDATA, S_DONE
  } state_e;

  state_e               state_q;
  logic [7:0]           cols_q, attr_q;
  logic [5:0]           rows_q;
  tccw_pkg::in_item_t   item_q;
  logic [AW-1:0]        cursor_q;
  logic [PW-1:0]        total_q, tgt_q, ptr_q, dividend_q;
  logic [7:0]           rem_q, div_q, rdc_q, rda_q;
  logic [CW-1:0]        cnt_q;
  logic                 sc_q;
  logic                 out_valid_q;
  tccw_pkg::out_item_t  out_q;
  logic [15:0]          rd_q;

  logic [15:0] mem [CELL_COUNT];

  logic [7:0]    ecols;
  logic [5:0]    erows;
  logic [13:0]   prod;
  logic [PW-1:0] ecols_p, cur_eff, bs_tgt, copy_end;
  logic [8:0]    rem_sh;
  logic [7:0]    rem_new;
  logic          idx_ok;
  logic          mem_we;
  logic [AW-1:0] mem_wa, mem_ra;
  logic [15:0]   mem_wd, blank;

  always_comb begin
    if (cols_q == 8'd0) begin
      ecols = 8'd1;
    end else if ({1'b0, cols_q} > 9'(MAX_COLUMNS)) begin
      ecols = 8'(MAX_COLUMNS);
    end else begin
      ecols = cols_q;
    end
    if (rows_q == 6'd0) begin
      erows = 6'd1;
    end else if ({1'b0, rows_q} > 7'(MAX_ROWS)) begin
      erows = 6'(MAX_ROWS);
    end else begin
      erows = rows_q;
    end
  end

  assign prod     = 14'(ecols) * 14'(erows);
  assign ecols_p  = PW'(ecols);
  assign cur_eff  = (PW'(cursor_q) >= total_q) ? (total_q - ecols_p) : PW'(cursor_q);
  assign bs_tgt   = (cur_eff != '0) ? (cur_eff - PW'(1)) : '0;
  assign copy_end = total_q - ecols_p;
  assign rem_sh   = {rem_q, dividend_q[PW-1]};
  assign rem_new  = 8'((rem_sh >= {1'b0, div_q}) ? (rem_sh - {1'b0, div_q}) : rem_sh);
  assign idx_ok   = 32'(item_q.cell_index) < CELL_COUNT;
  assign blank    = {attr_q, tccw_pkg::CH_SPACE};

  always_comb begin
    mem_we = 1'b0;
    mem_wa = AW'(ptr_q);
    mem_wd = blank;
    mem_ra = (state_q == S_SCR_RD) ? AW'(ptr_q + ecols_p) : AW'(item_q.cell_index);
    unique case (state_q)
      S_CLEAR: begin
        mem_we = 1'b1;
        mem_wd = {tccw_pkg::RESET_ATTR, tccw_pkg::CH_SPACE};
      end
      S_DISP: begin
        if (item_q.character == tccw_pkg::CH_BACKSPACE) begin
          mem_we = 1'b1;
          mem_wa = AW'(bs_tgt);
        end else if (item_q.character != tccw_pkg::CH_NEWLINE &&
                     item_q.character != tccw_pkg::CH_TAB) begin
          mem_we = 1'b1;
          mem_wa = AW'(cur_eff);
          mem_wd = {attr_q, item_q.character};
        end
      end
      S_SCR_WR: begin
        mem_we = 1'b1;
        mem_wd = rd_q;
      end
      S_BLANK: mem_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_q <= mem[mem_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= tccw_pkg::RESET_COLUMNS;
      rows_q <= tccw_pkg::RESET_ROWS;
      attr_q <= tccw_pkg::RESET_ATTR;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        tccw_pkg::CFG_COLUMNS:   cols_q <= cfg_data_i;
        tccw_pkg::CFG_ROWS:      rows_q <= cfg_data_i[5:0];
        tccw_pkg::CFG_ATTRIBUTE: attr_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      ptr_q       <= '0;
      cursor_q    <= '0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      if (out_valid_q && !out_stall_i && state_q != S_DONE) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_CLEAR: begin
          ptr_q <= ptr_q + PW'(1);
          if (ptr_q == PW'(CELL_COUNT - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid_i) begin
            item_q  <= in_data_i;
            state_q <= (in_data_i.operation == tccw_pkg::OP_READ) ? S_RDADR : S_GEOM;
          end
        end
        S_GEOM: begin
          total_q <= PW'(prod);
          rdc_q   <= 8'd0;
          rda_q   <= 8'd0;
          sc_q    <= 1'b0;
          state_q <= S_DISP;
        end
        S_DISP: begin
          cursor_q   <= AW'((item_q.character == tccw_pkg::CH_BACKSPACE) ? bs_tgt : cur_eff);
          dividend_q <= cur_eff;
          rem_q      <= 8'd0;
          cnt_q      <= '0;
          if (item_q.character == tccw_pkg::CH_NEWLINE) begin
            div_q   <= ecols;
            state_q <= S_DIV;
          end else if (item_q.character == tccw_pkg::CH_TAB) begin
            div_q   <= 8'(TAB_STOP);
            state_q <= S_DIV;
          end else if (item_q.character == tccw_pkg::CH_BACKSPACE) begin
            state_q  <= S_DONE;
          end else begin
            tgt_q   <= cur_eff + PW'(1);
            state_q <= S_PLACE;
          end
        end
        S_DIV: begin
          rem_q      <= rem_new;
          dividend_q <= dividend_q << 1;
          cnt_q      <= cnt_q + CW'(1);
          if (cnt_q == CW'(PW - 1)) begin
            tgt_q   <= PW'(cursor_q) - PW'(rem_new) + PW'(div_q);
            state_q <= S_PLACE;
          end
        end
        S_PLACE: begin
          if (tgt_q < total_q) begin
            cursor_q <= AW'(tgt_q);
            state_q  <= S_DONE;
          end else if (copy_end == '0) begin
            ptr_q   <= '0;
            state_q <= S_BLANK;
          end else begin
            ptr_q   <= '0;
            state_q <= S_SCR_RD;
          end
        end
        S_SCR_RD: state_q <= S_SCR_WR;
        S_SCR_WR: begin
          if (ptr_q + PW'(1) == copy_end) begin
            ptr_q   <= copy_end;
            state_q <= S_BLANK;
          end else begin
            ptr_q   <= ptr_q + PW'(1);
            state_q <= S_SCR_RD;
          end
        end
        S_BLANK: begin
          ptr_q <= ptr_q + PW'(1);
          if (ptr_q == total_q - PW'(1)) begin
            cursor_q <= AW'(copy_end);
            sc_q     <= 1'b1;
            state_q  <= S_DONE;
          end
        end
        S_RDADR: state_q <= S_RDDATA;
        S_RDDATA: begin
          rdc_q   <= idx_ok ? rd_q[7:0] : 8'd0;
          rda_q   <= idx_ok ? rd_q[15:8] : 8'd0;
          sc_q    <= 1'b0;
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_q || !out_stall_i) begin
            out_q.cursor_position <= 12'(cursor_q);
            out_q.read_character  <= rdc_q;
            out_q.read_attribute  <= rda_q;
            out_q.scrolled        <= sc_q;
            out_valid_q           <= 1'b1;
            state_q               <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef ASSERT_OFF
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV |-> div_q != 8'd0)
    else $error("remainder unit running with zero divisor");

  a_cursor_on_screen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && item_q.operation == tccw_pkg::OP_PUT) |->
      PW'(cursor_q) < total_q)
    else $error("cursor beyond last cell after put");

  a_scroll_cursor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && sc_q) |-> PW'(cursor_q) == copy_end)
    else $error("scroll left cursor off the bottom row start");

  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> 32'(mem_wa) < CELL_COUNT)
    else $error("cell write outside the store");
`endif

endmodule
